>>> rtl/ucb1_arm_selector_assert.svh
// ---------------------------------------------------------------------------
// ucb1_arm_selector_assert.svh
// Assertion macros used by the ucb1_ctrl sequencer.
// ---------------------------------------------------------------------------
`ifndef UCB1_ARM_SELECTOR_ASSERT_SVH
`define UCB1_ARM_SELECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define UCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UCB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UCB_ASSERT(lbl, prop, msg)
`define UCB_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> rtl/ucb1_pkg.sv
// ---------------------------------------------------------------------------
// ucb1_pkg
// Types and fixed constants of the UCB1 arm selector.
// ---------------------------------------------------------------------------
package ucb1_pkg;

  localparam int TOTAL_W    = 19;
  localparam int FRAC_W     = 16;
  localparam int LOG_W      = 21;
  localparam int Y_W        = 31;
  localparam int TWOLN_W    = 22;
  localparam int SCORE_W    = 20;
  localparam int SQ_STEPS   = 19;
  localparam int SQ_IN_W    = 2 * SQ_STEPS;
  localparam int ROOT_W     = SQ_STEPS;
  localparam int SQ_REM_W   = 21;
  localparam int IDX_W      = 5;
  localparam int STEP_W     = 6;
  localparam int MASK_W     = 8;
  localparam int LOG_STEPS  = 16;

  localparam logic [16:0]        TWO_LN2_Q16 = 17'd90852;
  localparam logic [SCORE_W-1:0] SCORE_MAX   = 20'hFFFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 19'h7FFFF;

  // request codes
  localparam logic [1:0] REQ_SELECT = 2'd0;
  localparam logic [1:0] REQ_RECORD = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_RSVD   = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RECORD,
    OP_CLEAR,
    OP_CHECK,
    OP_LOG_INIT,
    OP_LOG_STEP,
    OP_TWOLN,
    OP_DIV_MEAN,
    OP_DIV_BONUS,
    OP_DIV_STEP,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_SCORE
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [IDX_W-1:0]  idx;
    logic [STEP_W-1:0] step;
    logic [2:0]        arm;
    logic              success;
  } dp_cmd_t;

  typedef struct packed {
    logic arm_en;  // current scan arm is enabled
    logic stop;    // select settled without scoring
  } dp_sts_t;

endpackage

>>> rtl/ucb1_arm_selector.sv
// ---------------------------------------------------------------------------
// ucb1_arm_selector
// UCB1 bandit arm selection with per-arm success and pull counters.
// ---------------------------------------------------------------------------
// Sequence: record and clear hold busy through the ST_RECORD or ST_CLEAR state
//   after acceptance. A select with an unpulled enabled arm (or no enabled arm)
//   goes from ST_CHECK to ST_DONE, which strobes its result; otherwise it runs
//   the log2 steps, then for each enabled arm the two serial divides, the square
//   root and the score. The serial divider is max(COUNT_BITS+16, 38) bits wide.
// Throughput: one transaction at a time; the shared 1-bit/cycle divider and
//   square-root unit set the select time. The receiver cannot stall.
// Reset: synchronous, active low; clears all counts and restores the mask
//   to all arms enabled.
// ---------------------------------------------------------------------------
module ucb1_arm_selector #(
  parameter int NUM_ARMS   = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration: enabled arm mask
  input  logic                        cfg_wr_en,
  input  logic [ucb1_pkg::MASK_W-1:0] cfg_enabled_mask,
  // request transaction
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_req_type,
  input  logic [2:0]                  in_arm,
  input  logic                        in_success,
  // result transaction, one-cycle strobe
  output logic                        out_valid,
  output logic [2:0]                  out_chosen_arm,
  output logic                        out_none_enabled
);

  ucb1_pkg::dp_cmd_t cmd;
  ucb1_pkg::dp_sts_t sts;

  // Sequencer: one state per datapath operation; counts log, divide
  // and root iterations and walks the arms in index order.
  ucb1_ctrl #(
    .NUM_ARMS   (NUM_ARMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .in_arm      (in_arm),
    .in_success  (in_success),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy),
    .out_valid   (out_valid)
  );

  // Datapath: counters, Q.16 log2 by repeated squaring, restoring
  // divider, bit-pair square root, saturating score and best tracking.
  // Ties keep the lower arm since only a strictly higher score replaces it.
  ucb1_dpath #(
    .NUM_ARMS   (NUM_ARMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_enabled_mask (cfg_enabled_mask),
    .cmd              (cmd),
    .sts              (sts),
    .chosen_arm       (out_chosen_arm),
    .none_enabled     (out_none_enabled)
  );

endmodule

>>> rtl/ucb1_dpath.sv
// ---------------------------------------------------------------------------
// ucb1_dpath
// Count storage, log2 unit, serial divider, serial square root and scoring.
// ---------------------------------------------------------------------------
module ucb1_dpath #(
  parameter int NUM_ARMS   = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [ucb1_pkg::MASK_W-1:0]     cfg_enabled_mask,
  input  ucb1_pkg::dp_cmd_t               cmd,
  output ucb1_pkg::dp_sts_t               sts,
  output logic [2:0]                      chosen_arm,
  output logic                            none_enabled
);

  localparam int AW     = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
  localparam int DIV_W  = (COUNT_BITS + 16 > 38) ? COUNT_BITS + 16 : 38;
  localparam int REM_W  = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0]             succ_cnt_r [NUM_ARMS];
  logic [COUNT_BITS-1:0]             pull_cnt_r [NUM_ARMS];
  logic [NUM_ARMS-1:0]               pulled_r;
  logic [ucb1_pkg::TOTAL_W-1:0]      total_r;
  logic [ucb1_pkg::MASK_W-1:0]       mask_r;
  logic [ucb1_pkg::Y_W-1:0]          y_r;
  logic [ucb1_pkg::LOG_W-1:0]        log_r;
  logic [ucb1_pkg::TWOLN_W-1:0]      twoln_r;
  logic [DIV_W-1:0]                  dvd_r;
  logic [REM_W-1:0]                  rem_r;
  logic [COUNT_BITS-1:0]             dsr_r;
  logic [ucb1_pkg::SCORE_W-1:0]      mean_r;
  logic [ucb1_pkg::SQ_IN_W-1:0]      sx_r;
  logic [ucb1_pkg::SQ_REM_W-1:0]     srem_r;
  logic [ucb1_pkg::ROOT_W-1:0]       root_r;
  logic [ucb1_pkg::SCORE_W-1:0]      best_r;
  logic [AW-1:0]                     pick_r;
  logic                              found_r;

  logic [NUM_ARMS-1:0]               mask_en;
  logic [NUM_ARMS-1:0]               unpulled;
  logic [AW-1:0]                     first_unp;
  logic [AW-1:0]                     rd_a;
  logic [COUNT_BITS-1:0]             succ_rd;
  logic [COUNT_BITS-1:0]             pull_rd;
  logic                              rec_hit;
  logic [ucb1_pkg::TOTAL_W-1:0]      k;
  logic [4:0]                        e;
  logic [2*ucb1_pkg::Y_W-1:0]        sq;
  logic [31:0]                       sq_t;
  logic [37:0]                       ln_prod;
  logic [REM_W-1:0]                  rem_sh;
  logic [ucb1_pkg::SQ_REM_W-1:0]     s_sh;
  logic [ucb1_pkg::SQ_REM_W-1:0]     s_trial;
  logic [ucb1_pkg::SCORE_W:0]        sum;
  logic [ucb1_pkg::SCORE_W-1:0]      score;
  logic [3:0]                        log_bit;

  always_comb begin
    for (int i = 0; i < NUM_ARMS; i++) begin
      mask_en[i] = (i < ucb1_pkg::MASK_W) ? mask_r[i % ucb1_pkg::MASK_W] : 1'b0;
    end
    unpulled  = mask_en & ~pulled_r;
    first_unp = '0;
    for (int i = NUM_ARMS - 1; i >= 0; i--) begin
      if (unpulled[i]) first_unp = AW'(i);
    end
  end

  assign rec_hit = ({3'b000, cmd.arm} < 6'(NUM_ARMS));
  assign rd_a    = (cmd.op == ucb1_pkg::OP_RECORD) ? AW'(cmd.arm) : cmd.idx[AW-1:0];
  assign succ_rd = succ_cnt_r[rd_a];
  assign pull_rd = pull_cnt_r[rd_a];

  assign sts.arm_en = mask_en[cmd.idx[AW-1:0]];
  assign sts.stop   = (|unpulled) || (mask_en == '0);

  // log2 front end: k = max(1, total), e = top set bit
  always_comb begin
    k = (total_r == '0) ? ucb1_pkg::TOTAL_W'(1) : total_r;
    e = '0;
    for (int b = 0; b < ucb1_pkg::TOTAL_W; b++) begin
      if (k[b]) e = 5'(b);
    end
  end

  assign sq      = y_r * y_r;
  assign sq_t    = sq[61:30];
  assign log_bit = 4'(6'd15 - cmd.step);
  assign ln_prod = log_r * ucb1_pkg::TWO_LN2_Q16;
  assign rem_sh  = {rem_r[REM_W-2:0], dvd_r[DIV_W-1]};
  assign s_sh    = {srem_r[ucb1_pkg::SQ_REM_W-3:0], sx_r[ucb1_pkg::SQ_IN_W-1 -: 2]};
  assign s_trial = {root_r, 2'b01};
  assign sum     = {1'b0, mean_r} + (ucb1_pkg::SCORE_W + 1)'(root_r);
  assign score   = (sum > {1'b0, ucb1_pkg::SCORE_MAX}) ? ucb1_pkg::SCORE_MAX
                                                       : sum[ucb1_pkg::SCORE_W-1:0];

  // control state: counts, mask, pick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ARMS; i++) begin
        succ_cnt_r[i] <= '0;
        pull_cnt_r[i] <= '0;
      end
      pulled_r <= '0;
      total_r  <= '0;
      mask_r   <= 8'hFF;
      found_r  <= 1'b0;
      pick_r   <= '0;
    end else begin
      if (cfg_wr_en) mask_r <= cfg_enabled_mask;
      case (cmd.op)
        ucb1_pkg::OP_RECORD: begin
          if (rec_hit) begin
            if (pull_rd != COUNT_MAX) pull_cnt_r[rd_a] <= pull_rd + 1'b1;
            if (cmd.success && succ_rd != COUNT_MAX) succ_cnt_r[rd_a] <= succ_rd + 1'b1;
            if (total_r != ucb1_pkg::TOTAL_MAX) total_r <= total_r + 1'b1;
            pulled_r[rd_a] <= 1'b1;
          end
        end
        ucb1_pkg::OP_CLEAR: begin
          for (int i = 0; i < NUM_ARMS; i++) begin
            succ_cnt_r[i] <= '0;
            pull_cnt_r[i] <= '0;
          end
          pulled_r <= '0;
          total_r  <= '0;
        end
        ucb1_pkg::OP_CHECK: begin
          found_r <= |unpulled;
          pick_r  <= first_unp;
        end
        ucb1_pkg::OP_SCORE: begin
          if (!found_r || score > best_r) begin
            found_r <= 1'b1;
            pick_r  <= rd_a;
          end
        end
        default: ;
      endcase
    end
  end

  // arithmetic payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      ucb1_pkg::OP_LOG_INIT: begin
        y_r   <= ucb1_pkg::Y_W'(k) << (5'd30 - e);
        log_r <= {e, 16'h0000};
      end
      ucb1_pkg::OP_LOG_STEP: begin
        if (sq_t[31]) begin
          y_r            <= sq_t[31:1];
          log_r[log_bit] <= 1'b1;
        end else begin
          y_r <= sq_t[30:0];
        end
      end
      ucb1_pkg::OP_TWOLN: twoln_r <= ln_prod[37:16];
      ucb1_pkg::OP_DIV_MEAN: begin
        dvd_r <= DIV_W'({succ_rd, 16'h0000});
        dsr_r <= (pull_rd == '0) ? COUNT_BITS'(1) : pull_rd;
        rem_r <= '0;
      end
      ucb1_pkg::OP_DIV_BONUS: begin
        mean_r <= (dvd_r > DIV_W'(ucb1_pkg::SCORE_MAX)) ? ucb1_pkg::SCORE_MAX
                                                        : dvd_r[ucb1_pkg::SCORE_W-1:0];
        dvd_r  <= DIV_W'({twoln_r, 16'h0000});
        rem_r  <= '0;
      end
      ucb1_pkg::OP_DIV_STEP: begin
        if (rem_sh >= {1'b0, dsr_r}) begin
          rem_r <= rem_sh - {1'b0, dsr_r};
          dvd_r <= {dvd_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
        end
      end
      ucb1_pkg::OP_SQRT_INIT: begin
        sx_r   <= dvd_r[ucb1_pkg::SQ_IN_W-1:0];
        srem_r <= '0;
        root_r <= '0;
      end
      ucb1_pkg::OP_SQRT_STEP: begin
        sx_r <= sx_r << 2;
        if (s_sh >= s_trial) begin
          srem_r <= s_sh - s_trial;
          root_r <= {root_r[ucb1_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          srem_r <= s_sh;
          root_r <= {root_r[ucb1_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      ucb1_pkg::OP_SCORE: begin
        if (!found_r || score > best_r) best_r <= score;
      end
      default: ;
    endcase
  end

  assign chosen_arm   = 3'(pick_r);
  assign none_enabled = !found_r;

endmodule

>>> rtl/ucb1_ctrl.sv
// ---------------------------------------------------------------------------
// ucb1_ctrl
// Sequencer: steps the datapath through record, clear and select.
// ---------------------------------------------------------------------------
`include "ucb1_arm_selector_assert.svh"

module ucb1_ctrl #(
  parameter int NUM_ARMS   = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_req_type,
  input  logic [2:0]         in_arm,
  input  logic               in_success,
  input  ucb1_pkg::dp_sts_t  sts,
  output ucb1_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);

  localparam int DIV_W = (COUNT_BITS + 16 > 38) ? COUNT_BITS + 16 : 38;
  localparam logic [ucb1_pkg::STEP_W-1:0] DIV_LAST = ucb1_pkg::STEP_W'(DIV_W - 1);
  localparam logic [ucb1_pkg::STEP_W-1:0] SQ_LAST  = ucb1_pkg::STEP_W'(ucb1_pkg::SQ_STEPS - 1);
  localparam logic [ucb1_pkg::STEP_W-1:0] LOG_LAST = ucb1_pkg::STEP_W'(ucb1_pkg::LOG_STEPS - 1);
  localparam logic [ucb1_pkg::IDX_W-1:0]  IDX_LAST = ucb1_pkg::IDX_W'(NUM_ARMS - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RECORD, ST_CLEAR, ST_CHECK, ST_LOG_INIT, ST_LOG, ST_TWOLN,
    ST_ARM, ST_DIV_M, ST_DIV_B_LOAD, ST_DIV_B, ST_SQ_LOAD, ST_SQ, ST_SCORE, ST_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [ucb1_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [ucb1_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [2:0]                   arm_r, arm_nxt;
  logic                         succ_r, succ_nxt;
  logic                         last_arm;

  assign last_arm = (idx_r == IDX_LAST);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    arm_nxt   = arm_r;
    succ_nxt  = succ_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          arm_nxt  = in_arm;
          succ_nxt = in_success;
          case (in_req_type)
            ucb1_pkg::REQ_SELECT: state_nxt = ST_CHECK;
            ucb1_pkg::REQ_RECORD: state_nxt = ST_RECORD;
            ucb1_pkg::REQ_CLEAR:  state_nxt = ST_CLEAR;
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RECORD, ST_CLEAR: state_nxt = ST_IDLE;
      ST_CHECK:    state_nxt = sts.stop ? ST_DONE : ST_LOG_INIT;
      ST_LOG_INIT: begin
        state_nxt = ST_LOG;
        step_nxt  = '0;
      end
      ST_LOG: begin
        step_nxt = step_r + 1'b1;
        if (step_r == LOG_LAST) state_nxt = ST_TWOLN;
      end
      ST_TWOLN: begin
        state_nxt = ST_ARM;
        idx_nxt   = '0;
      end
      ST_ARM: begin
        step_nxt = '0;
        if (sts.arm_en) begin
          state_nxt = ST_DIV_M;
        end else if (last_arm) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DIV_M: begin
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_LAST) state_nxt = ST_DIV_B_LOAD;
      end
      ST_DIV_B_LOAD: begin
        state_nxt = ST_DIV_B;
        step_nxt  = '0;
      end
      ST_DIV_B: begin
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_LAST) state_nxt = ST_SQ_LOAD;
      end
      ST_SQ_LOAD: begin
        state_nxt = ST_SQ;
        step_nxt  = '0;
      end
      ST_SQ: begin
        step_nxt = step_r + 1'b1;
        if (step_r == SQ_LAST) state_nxt = ST_SCORE;
      end
      ST_SCORE: begin
        if (last_arm) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ARM;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      step_r  <= '0;
      arm_r   <= '0;
      succ_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
      arm_r   <= arm_nxt;
      succ_r  <= succ_nxt;
    end
  end

  always_comb begin
    cmd.idx     = idx_r;
    cmd.step    = step_r;
    cmd.arm     = arm_r;
    cmd.success = succ_r;
    case (state_r)
      ST_RECORD:     cmd.op = ucb1_pkg::OP_RECORD;
      ST_CLEAR:      cmd.op = ucb1_pkg::OP_CLEAR;
      ST_CHECK:      cmd.op = ucb1_pkg::OP_CHECK;
      ST_LOG_INIT:   cmd.op = ucb1_pkg::OP_LOG_INIT;
      ST_LOG:        cmd.op = ucb1_pkg::OP_LOG_STEP;
      ST_TWOLN:      cmd.op = ucb1_pkg::OP_TWOLN;
      ST_ARM:        cmd.op = sts.arm_en ? ucb1_pkg::OP_DIV_MEAN : ucb1_pkg::OP_NONE;
      ST_DIV_M:      cmd.op = ucb1_pkg::OP_DIV_STEP;
      ST_DIV_B_LOAD: cmd.op = ucb1_pkg::OP_DIV_BONUS;
      ST_DIV_B:      cmd.op = ucb1_pkg::OP_DIV_STEP;
      ST_SQ_LOAD:    cmd.op = ucb1_pkg::OP_SQRT_INIT;
      ST_SQ:         cmd.op = ucb1_pkg::OP_SQRT_STEP;
      ST_SCORE:      cmd.op = ucb1_pkg::OP_SCORE;
      default:       cmd.op = ucb1_pkg::OP_NONE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  `UCB_ASSERT(a_strobe_single, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `UCB_ASSERT(a_accept_busy, (start && !busy && in_req_type != ucb1_pkg::REQ_RSVD) |=> busy, "accepted transaction did not raise busy")
  `UCB_ASSERT(a_log_range, (state_r == ST_LOG) |-> (step_r <= LOG_LAST), "log step counter overran")
  `UCB_ASSERT(a_scan_range, (state_r == ST_ARM) |-> (idx_r <= IDX_LAST), "arm scan index out of range")
  `UCB_ASSERT_RST(a_reset_idle, !rst_n |=> !busy, "not idle after reset")

endmodule
